// File: src/wsh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsh_pkg: shared types and constants for the WebSocket header parser
// Parse phases, RFC 6455 length codes and the length-kind encoding.
// ----------------------------------------------------------------------------
package wsh_pkg;

    // Parse phase, one-hot
    typedef enum logic [3:0] {
        PH_FIRST  = 4'b0001,
        PH_SECOND = 4'b0010,
        PH_EXTLEN = 4'b0100,
        PH_KEY    = 4'b1000
    } t_phase;

    // Length codes in byte 2
    localparam logic [6:0] LEN_CODE_MAX_SHORT = 7'd125;
    localparam logic [6:0] LEN_CODE_EXT16     = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64     = 7'd127;

    // Header byte counts at which each length section ends, and the key size
    localparam logic [3:0] HDR_BASE_BYTES  = 4'd2;
    localparam logic [3:0] HDR_END_EXT16   = 4'd4;
    localparam logic [3:0] HDR_END_EXT64   = 4'd10;
    localparam logic [3:0] HDR_KEY_BYTES   = 4'd4;

    // Length kind reported with each header
    localparam logic [1:0] KIND_ZERO  = 2'd0;
    localparam logic [1:0] KIND_SHORT = 2'd1;
    localparam logic [1:0] KIND_EXT16 = 2'd2;
    localparam logic [1:0] KIND_EXT64 = 2'd3;

    // Header byte count at the end of the extended length field
    function automatic logic [3:0] len_end(input logic [6:0] code);
        logic [3:0] v;
        v = HDR_BASE_BYTES;
        if (code == LEN_CODE_EXT16) begin
            v = HDR_END_EXT16;
        end else if (code == LEN_CODE_EXT64) begin
            v = HDR_END_EXT64;
        end
        return v;
    endfunction

    // Length kind for a 7-bit length code
    function automatic logic [1:0] len_kind(input logic [6:0] code);
        logic [1:0] v;
        if (code == 7'd0) begin
            v = KIND_ZERO;
        end else if (code <= LEN_CODE_MAX_SHORT) begin
            v = KIND_SHORT;
        end else if (code == LEN_CODE_EXT16) begin
            v = KIND_EXT16;
        end else begin
            v = KIND_EXT64;
        end
        return v;
    endfunction

endpackage
`default_nettype wire

// File: src/websocket_header_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// websocket_header_parser: RFC 6455 frame header parser
// Takes header bytes one per item and emits one item with all header fields
// on the byte that completes the header.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_in_byte
//  out     | output    | o_out_valid / i_out_ready  | o_fin_flag .. o_header_length
//
//  One byte is taken per cycle while o_in_ready is high; the parse state updates
//  on the accepting edge and a finished header appears in the output register
//  on the next cycle. o_in_ready drops only while a finished header waits and
//  i_out_ready is low. Reset (synchronous, active low) returns to the
//  first-byte phase and empties the output register; no clearing pass is needed.
// ----------------------------------------------------------------------------
module websocket_header_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_in_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_fin_flag,
    output logic             o_rsv_one,
    output logic             o_rsv_two,
    output logic             o_rsv_three,
    output logic [3:0]       o_frame_opcode,
    output logic             o_is_masked,
    output logic [1:0]       o_length_kind,
    output logic [63:0]      o_payload_length,
    output logic [31:0]      o_masking_key,
    output logic [3:0]       o_header_length
);

    // Parse state
    wsh_pkg::t_phase r_phase, n_phase;
    logic [3:0]  r_byte_count, n_byte_count;
    logic [7:0]  r_flags, n_flags;
    logic        r_mask, n_mask;
    logic [6:0]  r_len_code, n_len_code;
    logic [63:0] r_len_accum, n_len_accum;
    logic [31:0] r_key_accum, n_key_accum;
    logic        n_emit;

    // Output register
    logic        r_out_valid;
    logic [7:0]  r_out_flags;
    logic        r_out_mask;
    logic [1:0]  r_out_kind;
    logic [63:0] r_out_len;
    logic [31:0] r_out_key;
    logic [3:0]  r_out_hdr_len;

    logic in_accept;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    // Next parse state for the byte on the input
    always_comb begin
        n_phase      = r_phase;
        n_byte_count = r_byte_count;
        n_flags      = r_flags;
        n_mask       = r_mask;
        n_len_code   = r_len_code;
        n_len_accum  = r_len_accum;
        n_key_accum  = r_key_accum;
        n_emit       = 1'b0;
        unique case (r_phase)
            wsh_pkg::PH_SECOND: begin
                n_mask       = i_in_byte[7];
                n_len_code   = i_in_byte[6:0];
                n_byte_count = wsh_pkg::HDR_BASE_BYTES;
                n_len_accum  = 64'd0;
                n_key_accum  = 32'd0;
                if (i_in_byte[6:0] <= wsh_pkg::LEN_CODE_MAX_SHORT) begin
                    n_len_accum = {57'd0, i_in_byte[6:0]};
                    if (i_in_byte[7]) begin
                        n_phase = wsh_pkg::PH_KEY;
                    end else begin
                        n_emit = 1'b1;
                    end
                end else begin
                    n_phase = wsh_pkg::PH_EXTLEN;
                end
            end
            wsh_pkg::PH_EXTLEN: begin
                n_len_accum  = {r_len_accum[55:0], i_in_byte};
                n_byte_count = r_byte_count + 4'd1;
                if (n_byte_count >= wsh_pkg::len_end(r_len_code)) begin
                    if (r_mask) begin
                        n_phase = wsh_pkg::PH_KEY;
                    end else begin
                        n_emit = 1'b1;
                    end
                end
            end
            wsh_pkg::PH_KEY: begin
                n_key_accum  = {r_key_accum[23:0], i_in_byte};
                n_byte_count = r_byte_count + 4'd1;
                if (n_byte_count >=
                        wsh_pkg::len_end(r_len_code) + wsh_pkg::HDR_KEY_BYTES) begin
                    n_emit = 1'b1;
                end
            end
            default: begin
                n_flags      = i_in_byte;
                n_byte_count = 4'd1;
                n_phase      = wsh_pkg::PH_SECOND;
            end
        endcase
        // Return to the first byte once the header is done
        if (n_emit) begin
            n_phase      = wsh_pkg::PH_FIRST;
            n_byte_count = 4'd0;
        end
    end

    // Advance parse state on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= wsh_pkg::PH_FIRST;
            r_byte_count <= 4'd0;
            r_flags      <= 8'd0;
            r_mask       <= 1'b0;
            r_len_code   <= 7'd0;
            r_len_accum  <= 64'd0;
            r_key_accum  <= 32'd0;
        end else if (in_accept) begin
            r_phase      <= n_phase;
            r_byte_count <= n_byte_count;
            r_flags      <= n_flags;
            r_mask       <= n_mask;
            r_len_code   <= n_len_code;
            r_len_accum  <= n_len_accum;
            r_key_accum  <= n_key_accum;
        end
    end

    // Hold the result valid until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept && n_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Load the result payload
    always_ff @(posedge i_clk) begin
        if (in_accept && n_emit) begin
            r_out_flags   <= n_flags;
            r_out_mask    <= n_mask;
            r_out_kind    <= wsh_pkg::len_kind(n_len_code);
            r_out_len     <= n_len_accum;
            r_out_key     <= n_mask ? n_key_accum : 32'd0;
            r_out_hdr_len <= r_phase == wsh_pkg::PH_SECOND ? wsh_pkg::HDR_BASE_BYTES
                                                           : r_byte_count + 4'd1;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_fin_flag       = r_out_flags[7];
    assign o_rsv_one        = r_out_flags[6];
    assign o_rsv_two        = r_out_flags[5];
    assign o_rsv_three      = r_out_flags[4];
    assign o_frame_opcode   = r_out_flags[3:0];
    assign o_is_masked      = r_out_mask;
    assign o_length_kind    = r_out_kind;
    assign o_payload_length = r_out_len;
    assign o_masking_key    = r_out_key;
    assign o_header_length  = r_out_hdr_len;

    // Header lengths are always even
    a_hdr_len_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_header_length[0])
        else $error("odd header length");

    // An unmasked header carries a zero key
    a_key_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_is_masked) |-> o_masking_key == 32'd0)
        else $error("nonzero key on unmasked header");

    // Zero and short length kinds report the 7-bit code, at most 125
    a_short_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_length_kind[1]) |->
            o_payload_length <= {57'd0, wsh_pkg::LEN_CODE_MAX_SHORT})
        else $error("short length out of range");

    // A finished header sends the parser back to the first byte
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && n_emit) |=>
            (r_phase == wsh_pkg::PH_FIRST && r_byte_count == 4'd0 && o_out_valid))
        else $error("parser did not restart after header");

endmodule
`default_nettype wire
